@@ hw/rtl/bpfa_pkg.sv @@
`timescale 1ns / 1ps

package bpfa_pkg;

  localparam int POOL_PAGES = 4096;
  localparam int MAX_RUN    = 16;
  localparam int PAGE_BYTES = 4096;

  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int IDX_W      = $clog2(POOL_PAGES);
  localparam int CNT_W      = IDX_W + 1;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int NUM_WORDS  = POOL_PAGES / WORD_W;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int RUN_W      = $clog2(MAX_RUN + 1);
  localparam int ADDR_W     = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 1;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_PAGES = 1'b1;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST  = 32'h0010_0000;
  localparam logic [CNT_W-1:0]  POOL_PAGES_RST = CNT_W'(POOL_PAGES);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef struct packed {
    logic               ren;
    logic [WADDR_W-1:0] raddr;
    logic               wen;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
  } mem_req_t;

endpackage

@@ hw/rtl/bpfa_map_mem.sv @@
`timescale 1ns / 1ps

module bpfa_map_mem (
  input  logic                          clk,
  input  logic                          rst_n,
  input  bpfa_pkg::mem_req_t            req,
  output logic [bpfa_pkg::WORD_W-1:0]   rdata
);

  logic [bpfa_pkg::WORD_W-1:0]    mem [bpfa_pkg::NUM_WORDS];
  logic [bpfa_pkg::WORD_W-1:0]    raw_r;
  logic [bpfa_pkg::NUM_WORDS-1:0] vld_r;
  logic                           rvld_r;

  always_ff @(posedge clk) begin
    if (req.wen) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.ren) begin
      raw_r <= mem[req.raddr];
    end
  end

  // a word never written since reset reads as all free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.wen) begin
        vld_r[req.waddr] <= 1'b1;
      end
      if (req.ren) begin
        rvld_r <= vld_r[req.raddr];
      end
    end
  end

  assign rdata = rvld_r ? raw_r : '0;

endmodule

@@ hw/rtl/bpfa_word_search.sv @@
`timescale 1ns / 1ps

module bpfa_word_search (
  input  logic [bpfa_pkg::WORD_W-1:0]  used_word,
  input  logic [bpfa_pkg::WORD_W-1:0]  pool_mask,
  input  logic [bpfa_pkg::MAX_RUN-1:0] prev_free,
  input  logic [bpfa_pkg::RUN_W-1:0]   run_len,
  output logic                         hit,
  output logic [bpfa_pkg::BIT_W-1:0]   hit_pos,
  output logic [bpfa_pkg::MAX_RUN-1:0] top_free
);

  logic [bpfa_pkg::WORD_W-1:0]                  free_w;
  logic [bpfa_pkg::WORD_W+bpfa_pkg::MAX_RUN-1:0] ext;
  logic [bpfa_pkg::MAX_RUN-1:0]                 need;
  logic [bpfa_pkg::WORD_W-1:0]                  end_ok;

  assign free_w   = ~used_word & pool_mask;
  assign ext      = {free_w, prev_free};
  // top run_len bits of each window must be free
  assign need     = ~({bpfa_pkg::MAX_RUN{1'b1}} >> run_len);
  assign top_free = free_w[bpfa_pkg::WORD_W-1 -: bpfa_pkg::MAX_RUN];

  always_comb begin
    for (int j = 0; j < bpfa_pkg::WORD_W; j++) begin
      end_ok[j] = &(ext[j+1 +: bpfa_pkg::MAX_RUN] | ~need);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int j = bpfa_pkg::WORD_W - 1; j >= 0; j--) begin
      if (end_ok[j]) begin
        hit_pos = bpfa_pkg::BIT_W'(j);
      end
    end
  end

  assign hit = |end_ok;

endmodule

@@ hw/rtl/bitmap_page_frame_allocator_core.sv @@
`timescale 1ns / 1ps

// First-fit page frame allocator over a 4096-page used-bit map held as 64 words of
// 64 bits in one synchronous RAM. One request at a time: an allocate scans the map a
// word per cycle from the lowest page and stops at the first fitting run. A run that
// straddles two words needs a second map write. The map RAM has a single read port,
// one word per cycle. The next request can be taken in the cycle after the result is
// loaded, while that result may still wait on the output. Reset takes effect at once:
// the map needs no clearing pass, since per-word valid flags make unwritten words
// read as free.
module bitmap_page_frame_allocator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [39:0]                       in_tdata,   // run_pages[4:0], free_address[36:5]
  input  logic                              in_tuser,   // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [31:0]                       out_tdata,  // page_address[31:0]
  output logic [1:0]                        out_tuser,  // status
  input  logic                              cfg_we,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpfa_pkg::CFG_W-1:0]        cfg_wdata
);

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_SCAN, S_MRD, S_MWR0, S_MWR1, S_DONE
  } state_t;

  localparam int IW = bpfa_pkg::IDX_W;
  localparam int AW = bpfa_pkg::ADDR_W;
  localparam int RW = bpfa_pkg::RUN_W;
  localparam int WW = bpfa_pkg::WORD_W;
  localparam int OFF_W = AW - bpfa_pkg::PAGE_SHIFT;

  state_t                          state_r, state_nxt;
  logic                            kind_r, kind_nxt;
  logic [RW-1:0]                   n_r, n_nxt;
  logic [AW-1:0]                   faddr_r, faddr_nxt;
  logic [bpfa_pkg::WADDR_W:0]      iss_r, iss_nxt;
  logic [bpfa_pkg::WADDR_W-1:0]    ev_r, ev_nxt;
  logic                            pend_r, pend_nxt;
  logic [bpfa_pkg::MAX_RUN-1:0]    prev_free_r, prev_free_nxt;
  logic [IW-1:0]                   s_r, s_nxt;
  logic                            set_r, set_nxt;
  logic [AW-1:0]                   res_addr_r, res_addr_nxt;
  bpfa_pkg::status_t               res_status_r, res_status_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [AW-1:0]                   out_addr_r, out_addr_nxt;
  bpfa_pkg::status_t               out_status_r, out_status_nxt;
  logic [AW-1:0]                   base_r, base_nxt;
  logic [bpfa_pkg::CNT_W-1:0]      pages_r, pages_nxt;

  bpfa_pkg::mem_req_t              mem_req;
  logic [WW-1:0]                   rdata;

  logic [bpfa_pkg::CNT_W-1:0]      total;
  logic [WW-1:0]                   pool_mask;
  logic                            hit;
  logic [bpfa_pkg::BIT_W-1:0]      hit_pos;
  logic [bpfa_pkg::MAX_RUN-1:0]    top_free;

  logic                            bad_cnt;
  logic                            below;
  logic [AW-1:0]                   off;
  logic [OFF_W-1:0]                fidx;
  logic [OFF_W:0]                  fend;
  logic [2*WW-1:0]                 run_mask;
  logic                            span;
  logic [bpfa_pkg::WADDR_W-1:0]    wa0, wa1;
  logic [WW-1:0]                   wr_lo, wr_hi;
  logic                            out_load;

  bpfa_map_mem u_map (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mem_req),
    .rdata (rdata)
  );

  bpfa_word_search u_search (
    .used_word (rdata),
    .pool_mask (pool_mask),
    .prev_free (prev_free_r),
    .run_len   (n_r),
    .hit       (hit),
    .hit_pos   (hit_pos),
    .top_free  (top_free)
  );

  assign total = (pages_r > bpfa_pkg::CNT_W'(bpfa_pkg::POOL_PAGES))
               ? bpfa_pkg::CNT_W'(bpfa_pkg::POOL_PAGES) : pages_r;

  // pages at or past the active pool end look used to the search
  always_comb begin
    if ({1'b0, ev_r} < total[bpfa_pkg::CNT_W-1:bpfa_pkg::BIT_W]) begin
      pool_mask = '1;
    end else if ({1'b0, ev_r} == total[bpfa_pkg::CNT_W-1:bpfa_pkg::BIT_W]) begin
      pool_mask = (WW'(1) << total[bpfa_pkg::BIT_W-1:0]) - WW'(1);
    end else begin
      pool_mask = '0;
    end
  end

  assign bad_cnt = (n_r == '0) || (n_r > RW'(bpfa_pkg::MAX_RUN));
  assign below   = faddr_r < base_r;
  assign off     = faddr_r - base_r;
  assign fidx    = off[AW-1:bpfa_pkg::PAGE_SHIFT];
  assign fend    = {1'b0, fidx} + (OFF_W+1)'(n_r);

  assign run_mask = ((2*WW)'(1) << n_r) - (2*WW)'(1) << s_r[bpfa_pkg::BIT_W-1:0];
  assign span     = |run_mask[2*WW-1:WW];
  assign wa0      = s_r[IW-1:bpfa_pkg::BIT_W];
  assign wa1      = wa0 + bpfa_pkg::WADDR_W'(1);
  assign wr_lo    = set_r ? (rdata | run_mask[WW-1:0]) : (rdata & ~run_mask[WW-1:0]);
  assign wr_hi    = set_r ? (rdata | run_mask[2*WW-1:WW]) : (rdata & ~run_mask[2*WW-1:WW]);

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_tready);

  always_comb begin
    mem_req = '0;
    unique case (state_r)
      S_SCAN: begin
        mem_req.ren   = !iss_r[bpfa_pkg::WADDR_W];
        mem_req.raddr = iss_r[bpfa_pkg::WADDR_W-1:0];
      end
      S_MRD: begin
        mem_req.ren   = 1'b1;
        mem_req.raddr = wa0;
      end
      S_MWR0: begin
        mem_req.wen   = 1'b1;
        mem_req.waddr = wa0;
        mem_req.wdata = wr_lo;
        mem_req.ren   = span;
        mem_req.raddr = wa1;
      end
      S_MWR1: begin
        mem_req.wen   = 1'b1;
        mem_req.waddr = wa1;
        mem_req.wdata = wr_hi;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    n_nxt          = n_r;
    faddr_nxt      = faddr_r;
    iss_nxt        = iss_r;
    ev_nxt         = ev_r;
    pend_nxt       = 1'b0;
    prev_free_nxt  = prev_free_r;
    s_nxt          = s_r;
    set_nxt        = set_r;
    res_addr_nxt   = res_addr_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_addr_nxt   = out_addr_r;
    out_status_nxt = out_status_r;
    base_nxt       = base_r;
    pages_nxt      = pages_r;

    if (cfg_we) begin
      unique case (cfg_index)
        bpfa_pkg::CFG_POOL_BASE:  base_nxt  = cfg_wdata;
        bpfa_pkg::CFG_POOL_PAGES: pages_nxt = cfg_wdata[bpfa_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          n_nxt     = in_tdata[RW-1:0];
          faddr_nxt = in_tdata[RW +: AW];
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        res_addr_nxt  = '0;
        iss_nxt       = '0;
        prev_free_nxt = '0;
        if (bad_cnt) begin
          res_status_nxt = bpfa_pkg::ST_BAD;
          state_nxt      = S_DONE;
        end else if (kind_r == bpfa_pkg::KIND_ALLOC) begin
          set_nxt   = 1'b1;
          state_nxt = S_SCAN;
        end else if (below || (fend > (OFF_W+1)'(total))) begin
          res_status_nxt = bpfa_pkg::ST_BAD;
          state_nxt      = S_DONE;
        end else begin
          set_nxt        = 1'b0;
          s_nxt          = fidx[IW-1:0];
          res_status_nxt = bpfa_pkg::ST_OK;
          state_nxt      = S_MRD;
        end
      end
      S_SCAN: begin
        // reads run one word ahead of the search
        if (!iss_r[bpfa_pkg::WADDR_W]) begin
          iss_nxt  = iss_r + 1'b1;
          pend_nxt = 1'b1;
          ev_nxt   = iss_r[bpfa_pkg::WADDR_W-1:0];
        end
        if (pend_r) begin
          prev_free_nxt = top_free;
          if (hit) begin
            s_nxt          = {ev_r, hit_pos} - IW'(n_r) + IW'(1);
            res_status_nxt = bpfa_pkg::ST_OK;
            pend_nxt       = 1'b0;
            state_nxt      = S_MRD;
          end else if (ev_r == bpfa_pkg::WADDR_W'(bpfa_pkg::NUM_WORDS - 1)) begin
            res_status_nxt = bpfa_pkg::ST_NOSPACE;
            pend_nxt       = 1'b0;
            state_nxt      = S_DONE;
          end
        end
      end
      S_MRD: begin
        if (set_r) begin
          res_addr_nxt = base_r + (AW'(s_r) << bpfa_pkg::PAGE_SHIFT);
        end
        state_nxt = S_MWR0;
      end
      S_MWR0: begin
        state_nxt = span ? S_MWR1 : S_DONE;
      end
      S_MWR1: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_addr_nxt   = res_addr_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= bpfa_pkg::POOL_BASE_RST;
      pages_r     <= bpfa_pkg::POOL_PAGES_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      base_r      <= base_nxt;
      pages_r     <= pages_nxt;
    end
    kind_r       <= kind_nxt;
    n_r          <= n_nxt;
    faddr_r      <= faddr_nxt;
    iss_r        <= iss_nxt;
    ev_r         <= ev_nxt;
    prev_free_r  <= prev_free_nxt;
    s_r          <= s_nxt;
    set_r        <= set_nxt;
    res_addr_r   <= res_addr_nxt;
    res_status_r <= res_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_addr_r;
  assign out_tuser  = out_status_r;

  // a write and a read of the same map word never share a cycle
  a_no_rw_collide: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_req.wen && mem_req.ren) |-> (mem_req.waddr != mem_req.raddr))
    else $error("map word read and written in the same cycle");

  // a straddling run never starts in the last word
  a_span_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR0 && span) |-> (wa0 != bpfa_pkg::WADDR_W'(bpfa_pkg::NUM_WORDS - 1)))
    else $error("run straddles past the end of the map");

  // failed requests always report address zero
  a_fail_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && res_status_r != bpfa_pkg::ST_OK) |-> (res_addr_r == '0))
    else $error("failed request with nonzero address");

  // a transaction is taken only after the previous result was loaded into the output register
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("second request taken while one is in flight");

endmodule
